/* rtl/core/swsq_pkg.sv */
// ----------------------------------------------------------------------------
// swsq_pkg
// shared types and constants of the stop-and-wait sender queue
// ----------------------------------------------------------------------------
`default_nettype none

package swsq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 64;
  localparam int FIELD_W             = 16;
  localparam int OPC_W               = 2;
  localparam int LIMIT_W             = 7;
  localparam int LENGTH_W            = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // input opcodes
  localparam logic [OPC_W-1:0] OPC_ARRIVE   = 2'd0;
  localparam logic [OPC_W-1:0] OPC_FEEDBACK = 2'd1;
  localparam logic [OPC_W-1:0] OPC_TICK     = 2'd2;

  // item class after decode; unused opcodes become a no-op item
  typedef enum logic [1:0] {
    K_ARRIVE,
    K_FEEDBACK,
    K_TICK,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] dur;
  } item_t;

  // back end sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/stop_and_wait_sender_queue.sv */
// ----------------------------------------------------------------------------
// stop_and_wait_sender_queue
// stop-and-wait packet sender with a drop-tail packet queue
// ----------------------------------------------------------------------------
// Every input transaction (packet arrival, feedback or time tick) yields
// exactly one result transaction, in order. A two-entry input queue in the
// front end decodes and holds items so the source is not stalled while the
// back end works or while a result waits to be popped, until both entries
// are full. An item that sends nothing is done in the idle state; one that
// sends a packet goes through state update, registered read of the head
// entry of the packet memory and send, and no new item is taken until that
// send is done, nor while a result waits to be popped. The registered read
// port of the packet memory, which has one write port at the tail and one
// read port at the head, is why a send needs its own read step. The packet
// memory has no reset and needs no clearing pass: only written entries are
// ever read. queue_limit may be written only while the block is idle; a
// limit above the queue depth acts as the depth, and zero drops every arrival.
// ----------------------------------------------------------------------------
`default_nettype none

module stop_and_wait_sender_queue #(
  parameter int QUEUE_DEPTH = swsq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [swsq_pkg::OPC_W-1:0]    in_opcode,
  input  wire logic [swsq_pkg::FIELD_W-1:0]  in_packet_id,
  input  wire logic [swsq_pkg::FIELD_W-1:0]  in_packet_duration,
  // result channel
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic                               out_sent_valid,
  output logic [swsq_pkg::FIELD_W-1:0]       out_sent_id,
  output logic [swsq_pkg::FIELD_W-1:0]       out_sent_duration,
  output logic                               out_dropped,
  output logic [swsq_pkg::LENGTH_W-1:0]      out_queue_length,
  // configuration channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [swsq_pkg::LIMIT_W-1:0]  cfg_queue_limit
);
  import swsq_pkg::*;

  logic [LIMIT_W-1:0] queue_limit_r, queue_limit_nxt;
  logic               q_valid;
  item_t              q_item;
  logic               q_deq;

  // config writes are always taken
  assign cfg_ready       = 1'b1;
  assign queue_limit_nxt = (cfg_valid && cfg_ready) ? cfg_queue_limit : queue_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_limit_r <= LIMIT_RESET;
    end else begin
      queue_limit_r <= queue_limit_nxt;
    end
  end

  // front end: accept and decode
  swsq_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_opcode          (in_opcode),
    .in_packet_id       (in_packet_id),
    .in_packet_duration (in_packet_duration),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_deq              (q_deq)
  );

  // back end: queue, timer, send decision, result register
  swsq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .queue_limit       (queue_limit_r),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_deq             (q_deq),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_sent_valid    (out_sent_valid),
    .out_sent_id       (out_sent_id),
    .out_sent_duration (out_sent_duration),
    .out_dropped       (out_dropped),
    .out_queue_length  (out_queue_length)
  );

  a_cfg_load: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> (queue_limit_r == $past(cfg_queue_limit)))
    else $error("queue limit not loaded on config write");

  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_valid |=> $stable(queue_limit_r))
    else $error("queue limit changed without a config write");

  a_out_sent_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_sent_valid) |->
      (out_sent_id == '0) && (out_sent_duration == '0))
    else $error("result without a send carries packet fields");

endmodule

`default_nettype wire

/* rtl/core/swsq_front.sv */
// ----------------------------------------------------------------------------
// swsq_front
// accepts input transactions, decodes the opcode and holds them in a
// two-entry queue for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module swsq_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [swsq_pkg::OPC_W-1:0]    in_opcode,
  input  wire logic [swsq_pkg::FIELD_W-1:0]  in_packet_id,
  input  wire logic [swsq_pkg::FIELD_W-1:0]  in_packet_duration,
  output logic                               q_valid,
  output swsq_pkg::item_t                    q_item,
  input  wire logic                          q_deq
);
  import swsq_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       enq;
  logic       deq;
  item_t      dec_item;

  // opcode decode
  always_comb begin
    dec_item.id  = in_packet_id;
    dec_item.dur = in_packet_duration;
    unique case (in_opcode)
      OPC_ARRIVE:   dec_item.kind = K_ARRIVE;
      OPC_FEEDBACK: dec_item.kind = K_FEEDBACK;
      OPC_TICK:     dec_item.kind = K_TICK;
      default:      dec_item.kind = K_NOP;
    endcase
  end

  assign in_full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = slot_r[rd_ptr_r];
  assign enq     = in_push && !in_full;
  assign deq     = q_deq && q_valid;

  always_comb begin
    wr_ptr_nxt = enq ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = deq ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, enq} - {1'b0, deq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      slot_r[wr_ptr_r] <= dec_item;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("front queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("front queue pointers disagree with count");

  a_deq_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (q_deq && !q_valid) |=> $stable(cnt_r))
    else $error("dequeue from empty front queue changed its count");

endmodule

`default_nettype wire

/* rtl/core/swsq_back.sv */
// ----------------------------------------------------------------------------
// swsq_back
// carries out decoded items: packet queue memory, may-send flag, service
// timer, send decision and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module swsq_back #(
  parameter int QUEUE_DEPTH = swsq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [swsq_pkg::LIMIT_W-1:0]  queue_limit,
  input  wire logic                          q_valid,
  input  wire swsq_pkg::item_t               q_item,
  output logic                               q_deq,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic                               out_sent_valid,
  output logic [swsq_pkg::FIELD_W-1:0]       out_sent_id,
  output logic [swsq_pkg::FIELD_W-1:0]       out_sent_duration,
  output logic                               out_dropped,
  output logic [swsq_pkg::LENGTH_W-1:0]      out_queue_length
);
  import swsq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

  logic [2*FIELD_W-1:0] mem [QUEUE_DEPTH];
  logic [2*FIELD_W-1:0] rd_data_r;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               may_r, may_nxt;
  logic               busy_r, busy_nxt;
  logic [FIELD_W-1:0] rem_r, rem_nxt;
  logic [FIELD_W-1:0] rem_dec;
  logic               dropped_r, dropped_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_free;
  logic               wr_en;
  logic               send_go;
  logic               res_load;
  logic               res_sent;
  logic [FIELD_W-1:0] res_id;
  logic [FIELD_W-1:0] res_dur;
  logic               res_dropped;
  logic [LENGTH_W-1:0] res_len;

  logic [LW-1:0]      lim_ext;
  logic [LW-1:0]      limit_eff;
  logic               at_limit;
  logic [FIELD_W-1:0] head_dur;

  assign out_free = !out_valid_r || out_pop;
  assign head_dur = rd_data_r[2*FIELD_W-1:FIELD_W];

  // limit above the depth acts as the depth
  always_comb begin
    lim_ext   = LW'(queue_limit);
    limit_eff = (lim_ext > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH) : lim_ext;
    at_limit  = (LW'(count_r) >= limit_eff);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_valid && out_free && send_go) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_SEND;
      ST_SEND: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    may_nxt     = may_r;
    busy_nxt    = busy_r;
    rem_nxt     = rem_r;
    dropped_nxt = dropped_r;
    rem_dec     = (rem_r != '0) ? rem_r - 1'b1 : rem_r;
    wr_en       = 1'b0;
    q_deq       = 1'b0;
    send_go     = 1'b0;
    res_load    = 1'b0;
    res_sent    = 1'b0;
    res_id      = '0;
    res_dur     = '0;
    res_dropped = 1'b0;
    res_len     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_deq       = 1'b1;
          dropped_nxt = 1'b0;
          case (q_item.kind)
            K_ARRIVE: begin
              if (at_limit) begin
                dropped_nxt = 1'b1;
              end else begin
                wr_en     = 1'b1;
                tail_nxt  = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            K_FEEDBACK: may_nxt = 1'b1;
            K_TICK: begin
              if (busy_r) begin
                rem_nxt = rem_dec;
                if (rem_dec == '0) busy_nxt = 1'b0;
              end
            end
            default: ;
          endcase
          send_go = !busy_nxt && (count_nxt != '0) && may_nxt;
          if (!send_go) begin
            res_load    = 1'b1;
            res_dropped = dropped_nxt;
            res_len     = LENGTH_W'(count_nxt);
          end
        end
      end
      ST_READ: ;
      ST_SEND: begin
        if (out_free) begin
          res_load    = 1'b1;
          res_sent    = 1'b1;
          res_id      = rd_data_r[FIELD_W-1:0];
          res_dur     = head_dur;
          res_dropped = dropped_r;
          count_nxt   = count_r - 1'b1;
          res_len     = LENGTH_W'(count_nxt);
          head_nxt    = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
          may_nxt     = 1'b0;
          busy_nxt    = 1'b1;
          rem_nxt     = (head_dur == '0) ? FIELD_W'(1) : head_dur;
        end
      end
      default: ;
    endcase
    out_valid_nxt = res_load ? 1'b1 : (out_pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      may_r       <= 1'b1;
      busy_r      <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      may_r       <= may_nxt;
      busy_r      <= busy_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dropped_r <= dropped_nxt;
    if (res_load) begin
      out_sent_valid    <= res_sent;
      out_sent_id       <= res_id;
      out_sent_duration <= res_dur;
      out_dropped       <= res_dropped;
      out_queue_length  <= res_len;
    end
  end

  // packet store, registered read at the head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= {q_item.dur, q_item.id};
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[head_r];
  end

  assign out_empty = !out_valid_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("packet count above queue depth");

  a_busy_timer: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r != '0))
    else $error("server busy with an expired timer");

  a_send_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND) |-> (count_r != '0) && !busy_r && may_r)
    else $error("send without a packet, idle server and may-send");

  a_read_to_send: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_SEND))
    else $error("head read not followed by send");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && !out_pop) |-> !out_valid_r)
    else $error("result register overwritten before pop");

endmodule

`default_nettype wire
